// File: rtl/lsr_pkg.sv
`default_nettype none

package lsr_pkg;

    // list geometry
    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned DATA_W    = 32;

    // result field widths
    localparam int unsigned OP_W      = 3;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CNT_W     = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_INDEX  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

endpackage

`default_nettype wire

// File: rtl/lsr_if.sv
`default_nettype none

// request channel: operation and operand
interface lsr_req_if import lsr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

// result channel
interface lsr_rsp_if import lsr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         position;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;

    modport source (output valid, read_value, position, status, entry_count, input ready);
    modport sink   (input valid, read_value, position, status, entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/lsr_mem.sv
`default_nettype none

// entry store: one write port, one read port, registered read data
module lsr_mem
    import lsr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/lifo_list_with_search_remove_core.sv
// path from accept to result: push, clear, unused codes and empty list go straight to ST_DONE,
//   pop passes ST_POP, index-of scans in ST_SCAN, remove scans and closes the gap in ST_SHIFT
// throughput: one request at a time, next accept the cycle after the result is handed over;
//   time per request is set by the scan and gap closing through the single read port
// reset: asynchronous, active low; the list comes up empty, entry memory is not cleared
`default_nettype none

module lifo_list_with_search_remove_core
    import lsr_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    lsr_req_if.sink   req,
    lsr_rsp_if.source rsp
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // control sequencer, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POP   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // list storage: physical entry 0 is the oldest, count-1 is the front
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;      // address whose data sits in rdata
    logic [AW-1:0] top_addr;

    // request captured at accept
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] value_reg, value_next;

    // pending result
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;

    // output register
    logic              rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0] rsp_value_reg, rsp_value_next;
    logic [POS_W-1:0]  rsp_pos_reg, rsp_pos_next;
    logic [STAT_W-1:0] rsp_stat_reg, rsp_stat_next;
    logic [CNT_W-1:0]  rsp_cnt_reg, rsp_cnt_next;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    lsr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign top_addr  = AW'(count_reg - CW'(1));
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_value_reg;
    assign rsp.position    = rsp_pos_reg;
    assign rsp.status      = rsp_stat_reg;
    assign rsp.entry_count = rsp_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        res_value_next = res_value_reg;
        res_pos_next   = res_pos_reg;
        res_stat_next  = res_stat_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp.ready;
        rsp_value_next = rsp_value_reg;
        rsp_pos_next   = rsp_pos_reg;
        rsp_stat_next  = rsp_stat_reg;
        rsp_cnt_next   = rsp_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg - AW'(1);
        mem_wdata      = mem_rdata;
        mem_raddr      = top_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.op;
                    value_next     = req.value;
                    res_value_next = '0;
                    res_pos_next   = '0;
                    res_stat_next  = STAT_OK;
                    state_next     = ST_DONE;
                    case (req.op)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_stat_next = STAT_FULL;
                            end
                            else
                            begin
                                // new front goes just above the current front
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_POP;
                            end
                        end
                        OP_INDEX, OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // walk from the front toward the oldest entry
                                ptr_next   = top_addr;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused code: no change, zero result
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                res_value_next = mem_rdata;
                count_next     = count_reg - CW'(1);
                state_next     = ST_DONE;
            end

            ST_SCAN:
            begin
                // speculatively fetch the next older entry
                mem_raddr = ptr_reg - AW'(1);
                if (mem_rdata == value_reg)
                begin
                    res_pos_next = POS_W'(top_addr - ptr_reg);
                    if (op_reg == OP_REMOVE)
                    begin
                        if (ptr_reg == top_addr)
                        begin
                            // match at the front: just drop it
                            count_next = count_reg - CW'(1);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            // close the gap: move newer entries down one slot
                            mem_raddr  = ptr_reg + AW'(1);
                            ptr_next   = ptr_reg + AW'(1);
                            state_next = ST_SHIFT;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    res_stat_next = STAT_NOT_FOUND;
                    state_next    = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
            end

            ST_SHIFT:
            begin
                // rdata holds entry ptr; it moves to ptr-1 while ptr+1 is read, unless ptr is the front
                mem_we = 1'b1;
                if (ptr_reg == top_addr)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_raddr = ptr_reg + AW'(1);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end

            ST_DONE:
            begin
                // hand the result over once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_value_next = res_value_reg;
                    rsp_pos_next   = res_pos_reg;
                    rsp_stat_next  = res_stat_reg;
                    rsp_cnt_next   = CNT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        op_reg        <= op_next;
        value_reg     <= value_next;
        res_value_reg <= res_value_next;
        res_pos_reg   <= res_pos_next;
        res_stat_reg  <= res_stat_next;
        rsp_value_reg <= rsp_value_next;
        rsp_pos_reg   <= rsp_pos_next;
        rsp_stat_reg  <= rsp_stat_next;
        rsp_cnt_reg   <= rsp_cnt_next;
    end

endmodule

`default_nettype wire
